// ===== design/ptc_pkg.sv =====
package ptc_pkg;

  localparam int DIV_BITS = 64;
  localparam int DEN_W    = 31;
  localparam int PRE_STAGES  = 10;
  localparam int POST_STAGES = 6;

  localparam logic [1:0] CFG_CAL_TEMP    = 2'd0;
  localparam logic [1:0] CFG_CAL_PRESS_A = 2'd1;
  localparam logic [1:0] CFG_CAL_PRESS_B = 2'd2;
  localparam logic [1:0] CFG_CAL_PRESS_C = 2'd3;

  localparam logic signed [24:0] TF_OFFSET  = 25'sd128000;
  localparam logic [20:0]        PRESS_ONE  = 21'd1048576;
  localparam logic [11:0]        PRESS_MULT = 12'd3125;
  localparam logic signed [35:0] TC_ROUND   = 36'sd128;
  localparam logic [63:0]        V1_BIAS    = 64'h0000_8000_0000_0000;

  typedef struct packed {
    logic signed [15:0] tc;
    logic signed [31:0] tf;
  } ptc_temp_t;

  typedef struct packed {
    logic      neg;
    logic      fault;
    ptc_temp_t temp;
  } ptc_side_t;

endpackage

// ===== design/ptc_div.sv =====
module ptc_div
  import ptc_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                in_vld,
  input  logic [DIV_BITS-1:0] in_num,
  input  logic [DEN_W-1:0]    in_den,
  input  ptc_side_t           in_side,
  output logic                out_vld,
  output logic [DIV_BITS-1:0] out_quo,
  output ptc_side_t           out_side
);

  logic [DIV_BITS-1:0] vld_r;
  logic [DIV_BITS-1:0] num_r  [DIV_BITS];
  logic [DEN_W-1:0]    rem_r  [DIV_BITS];
  logic [DEN_W-1:0]    den_r  [DIV_BITS];
  ptc_side_t           side_r [DIV_BITS];

  for (genvar k = 0; k < DIV_BITS; k++) begin : g_stage
    logic                src_vld;
    logic [DIV_BITS-1:0] src_num;
    logic [DEN_W-1:0]    src_rem;
    logic [DEN_W-1:0]    src_den;
    ptc_side_t           src_side;
    logic [DEN_W-1:0]    trial;
    logic                ge;

    if (k == 0) begin : g_first
      assign src_vld  = in_vld;
      assign src_num  = in_num;
      assign src_rem  = '0;
      assign src_den  = in_den;
      assign src_side = in_side;
    end else begin : g_next
      assign src_vld  = vld_r[k-1];
      assign src_num  = num_r[k-1];
      assign src_rem  = rem_r[k-1];
      assign src_den  = den_r[k-1];
      assign src_side = side_r[k-1];
    end

    // one quotient bit per stage, shifted into the numerator word
    assign trial = {src_rem[DEN_W-2:0], src_num[DIV_BITS-1]};
    assign ge    = (trial >= src_den);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= src_vld;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        num_r[k]  <= {src_num[DIV_BITS-2:0], ge};
        rem_r[k]  <= ge ? (trial - src_den) : trial;
        den_r[k]  <= src_den;
        side_r[k] <= src_side;
      end
    end
  end

  assign out_vld  = vld_r[DIV_BITS-1];
  assign out_quo  = num_r[DIV_BITS-1];
  assign out_side = side_r[DIV_BITS-1];

endmodule

// ===== design/pressure_temperature_compensation.sv =====
// 10 front stages, 64 divider stages and 6 back stages lie between an accepted item and
// its result on out_tvalid
// throughput: one item per cycle while the output is not stalled, every stage including the divider is pipelined
// a stall at the output freezes the whole pipeline; in_tready follows it
// reset (synchronous, rst_n low) clears all valid bits and the calibration
// registers to zero
module pressure_temperature_compensation
  import ptc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // raw_temp[19:0], raw_press[39:20]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [79:0] out_tdata,  // temp_centi[15:0], fine_temp[47:16], pressure_q24_8[79:48]
  output logic        out_tuser,  // divide_fault
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [47:0] cfg_wdata
);

  logic [47:0] cal_r [4];
  logic        en;

  logic [15:0] t1, p1;
  logic signed [15:0] t2, t3, p2, p3, p4, p5, p6, p7, p8, p9;

  assign t1 = cal_r[CFG_CAL_TEMP][15:0];
  assign t2 = $signed(cal_r[CFG_CAL_TEMP][31:16]);
  assign t3 = $signed(cal_r[CFG_CAL_TEMP][47:32]);
  assign p1 = cal_r[CFG_CAL_PRESS_A][15:0];
  assign p2 = $signed(cal_r[CFG_CAL_PRESS_A][31:16]);
  assign p3 = $signed(cal_r[CFG_CAL_PRESS_A][47:32]);
  assign p4 = $signed(cal_r[CFG_CAL_PRESS_B][15:0]);
  assign p5 = $signed(cal_r[CFG_CAL_PRESS_B][31:16]);
  assign p6 = $signed(cal_r[CFG_CAL_PRESS_B][47:32]);
  assign p7 = $signed(cal_r[CFG_CAL_PRESS_C][15:0]);
  assign p8 = $signed(cal_r[CFG_CAL_PRESS_C][31:16]);
  assign p9 = $signed(cal_r[CFG_CAL_PRESS_C][47:32]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 4; i++) begin
        cal_r[i] <= '0;
      end
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_CAL_TEMP:    cal_r[CFG_CAL_TEMP]    <= cfg_wdata;
        CFG_CAL_PRESS_A: cal_r[CFG_CAL_PRESS_A] <= cfg_wdata;
        CFG_CAL_PRESS_B: cal_r[CFG_CAL_PRESS_B] <= cfg_wdata;
        CFG_CAL_PRESS_C: cal_r[CFG_CAL_PRESS_C] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  logic [PRE_STAGES-1:0]  pre_vld_r;
  logic [POST_STAGES-1:0] post_vld_r;
  logic                   div_out_vld;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pre_vld_r  <= '0;
      post_vld_r <= '0;
    end else if (en) begin
      pre_vld_r  <= {pre_vld_r[PRE_STAGES-2:0], in_tvalid};
      post_vld_r <= {post_vld_r[POST_STAGES-2:0], div_out_vld};
    end
  end

  // temperature path
  logic [19:0] at, ap;
  assign at = in_tdata[19:0];
  assign ap = in_tdata[39:20];

  logic signed [18:0] d1_r;
  logic signed [16:0] d2_r;
  logic signed [34:0] m1_r;
  logic signed [33:0] sq_r;
  logic signed [23:0] a_r;
  logic signed [37:0] m3_r;
  logic signed [21:0] bq;
  logic signed [31:0] tf_r;
  logic signed [35:0] t5;
  logic signed [27:0] tcs;
  logic signed [15:0] tc_nxt;
  logic [19:0]        ap_r [8];
  ptc_temp_t          tt_r [6];

  assign bq = 22'(sq_r >>> 12);

  always_ff @(posedge clk) begin
    if (en) begin
      d1_r  <= $signed({2'b00, at[19:3]}) - $signed({2'b00, t1, 1'b0});
      d2_r  <= $signed({1'b0, at[19:4]}) - $signed({1'b0, t1});
      ap_r[0] <= ap;
      m1_r  <= d1_r * t2;
      sq_r  <= d2_r * d2_r;
      ap_r[1] <= ap_r[0];
      a_r   <= 24'(m1_r >>> 11);
      m3_r  <= bq * t3;
      ap_r[2] <= ap_r[1];
      tf_r  <= 32'(a_r) + 32'(m3_r >>> 14);
      ap_r[3] <= ap_r[2];
    end
  end

  assign t5  = 36'(tf_r) * 36'sd5 + TC_ROUND;
  assign tcs = 28'(t5 >>> 8);

  always_comb begin
    if (tcs > 28'sd32767) begin
      tc_nxt = 16'sh7fff;
    end else if (tcs < -28'sd32768) begin
      tc_nxt = 16'sh8000;
    end else begin
      tc_nxt = 16'(tcs);
    end
  end

  // pressure path, all sums wrap at 64 bits
  logic signed [24:0] v1_r;
  logic [49:0]        vsq_r;
  logic signed [40:0] m5_r, m2_r;
  logic [63:0]        m5s_r, m2s_r;
  logic signed [48:0] pl6_r, pl3_r;
  logic [31:0]        ph6_r, ph3_r;
  logic signed [34:0] ph6w, ph3w;
  logic signed [49:0] vsqw;
  logic [63:0]        v2_r, v1b_r, v1x;
  logic [63:0]        x9;
  logic [47:0]        pl1_r, ph1w;
  logic [31:0]        ph1_r;
  logic [20:0]        pr;
  logic [63:0]        num0_r;
  logic [63:0]        x1;
  logic [DEN_W-1:0]   dv_r;
  logic [43:0]        nl_r, nhw;
  logic [31:0]        nh_r;

  assign vsqw = v1_r * v1_r;
  assign ph6w = $signed({1'b0, vsq_r[49:32]}) * p6;
  assign ph3w = $signed({1'b0, vsq_r[49:32]}) * p3;
  assign v1x  = 64'(pl3_r) + {ph3_r, 32'b0};
  assign x9   = v1b_r + V1_BIAS;
  assign ph1w = x9[63:32] * p1;
  assign pr   = PRESS_ONE - {1'b0, ap_r[7]};
  assign x1   = {16'b0, pl1_r} + {ph1_r, 32'b0};
  assign nhw  = num0_r[63:32] * PRESS_MULT;

  always_ff @(posedge clk) begin
    if (en) begin
      v1_r     <= 25'(tf_r) - TF_OFFSET;
      tt_r[0]  <= '{tc: tc_nxt, tf: tf_r};
      ap_r[4]  <= ap_r[3];
      vsq_r    <= 50'(vsqw);
      m5_r     <= v1_r * p5;
      m2_r     <= v1_r * p2;
      tt_r[1]  <= tt_r[0];
      ap_r[5]  <= ap_r[4];
      pl6_r    <= $signed({1'b0, vsq_r[31:0]}) * p6;
      ph6_r    <= ph6w[31:0];
      pl3_r    <= $signed({1'b0, vsq_r[31:0]}) * p3;
      ph3_r    <= ph3w[31:0];
      m5s_r    <= 64'(m5_r) << 17;
      m2s_r    <= 64'(m2_r) << 12;
      tt_r[2]  <= tt_r[1];
      ap_r[6]  <= ap_r[5];
      v2_r     <= 64'(pl6_r) + {ph6_r, 32'b0} + m5s_r + (64'(p4) << 35);
      v1b_r    <= 64'($signed(v1x) >>> 8) + m2s_r;
      tt_r[3]  <= tt_r[2];
      ap_r[7]  <= ap_r[6];
      pl1_r    <= x9[31:0] * p1;
      ph1_r    <= ph1w[31:0];
      num0_r   <= 64'({pr, 31'b0}) - v2_r;
      tt_r[4]  <= tt_r[3];
      dv_r     <= x1[63:33];
      nl_r     <= num0_r[31:0] * PRESS_MULT;
      nh_r     <= nhw[31:0];
      tt_r[5]  <= tt_r[4];
    end
  end

  logic [63:0]      num;
  logic [63:0]      div_num;
  logic [DEN_W-1:0] div_den;
  ptc_side_t        div_side;

  assign num      = {20'b0, nl_r} + {nh_r, 32'b0};
  assign div_num  = num[63] ? (64'd0 - num) : num;
  assign div_den  = dv_r[DEN_W-1] ? (~dv_r + 31'd1) : dv_r;
  assign div_side = '{neg: num[63] ^ dv_r[DEN_W-1], fault: (dv_r == '0), temp: tt_r[5]};

  logic [63:0] quo;
  ptc_side_t   quo_side;

  ptc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (pre_vld_r[PRE_STAGES-1]),
    .in_num   (div_num),
    .in_den   (div_den),
    .in_side  (div_side),
    .out_vld  (div_out_vld),
    .out_quo  (quo),
    .out_side (quo_side)
  );

  // final pressure correction
  logic [63:0] pq_r [4];
  ptc_side_t   ps_r [5];
  logic [63:0] s, sl2_r, ss_r, bb, b_r [2], aa, sum_r, r;
  logic [31:0] cr_r, ph8_r, ph9_r;
  logic [63:0] crw;
  logic signed [48:0] pl8_r, pl9_r;
  logic signed [48:0] ph8w, ph9w;
  logic [31:0] press_nxt;

  assign s    = 64'($signed(pq_r[0]) >>> 13);
  assign crw  = s[31:0] * s[63:32];
  assign ph8w = $signed({1'b0, pq_r[0][63:32]}) * p8;
  assign bb   = 64'(pl8_r) + {ph8_r, 32'b0};
  assign ph9w = $signed({1'b0, ss_r[63:32]}) * p9;
  assign aa   = 64'(pl9_r) + {ph9_r, 32'b0};
  assign r    = 64'($signed(sum_r) >>> 8) + (64'(p7) << 4);

  always_ff @(posedge clk) begin
    if (en) begin
      pq_r[0] <= quo_side.neg ? (64'd0 - quo) : quo;
      ps_r[0] <= quo_side;
      sl2_r   <= s[31:0] * s[31:0];
      cr_r    <= crw[31:0];
      pl8_r   <= $signed({1'b0, pq_r[0][31:0]}) * p8;
      ph8_r   <= ph8w[31:0];
      pq_r[1] <= pq_r[0];
      ps_r[1] <= ps_r[0];
      ss_r    <= sl2_r + {cr_r[30:0], 1'b0, 32'b0};
      b_r[0]  <= 64'($signed(bb) >>> 19);
      pq_r[2] <= pq_r[1];
      ps_r[2] <= ps_r[1];
      pl9_r   <= $signed({1'b0, ss_r[31:0]}) * p9;
      ph9_r   <= ph9w[31:0];
      b_r[1]  <= b_r[0];
      pq_r[3] <= pq_r[2];
      ps_r[3] <= ps_r[2];
      sum_r   <= pq_r[3] + 64'($signed(aa) >>> 25) + b_r[1];
      ps_r[4] <= ps_r[3];
    end
  end

  always_comb begin
    if (ps_r[4].fault || r[63]) begin
      press_nxt = '0;
    end else if (r[63:32] != '0) begin
      press_nxt = 32'hffff_ffff;
    end else begin
      press_nxt = r[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_tdata <= {press_nxt, ps_r[4].temp.tf, ps_r[4].temp.tc};
      out_tuser <= ps_r[4].fault;
    end
  end

  assign out_tvalid = post_vld_r[POST_STAGES-1];

  a_fault_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata[79:48] == 32'd0)
    else $error("divide fault with nonzero pressure");

  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> pre_vld_r[0])
    else $error("accepted item not captured");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(pre_vld_r) && $stable(post_vld_r))
    else $error("pipeline moved during stall");

endmodule

// ===== bench/tb_top.sv =====
module tb_top;
  import ptc_pkg::*;

  typedef struct packed {
    bit [15:0] tc;
    bit [31:0] tf;
    bit [31:0] press;
    bit        fault;
  } comp_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [39:0] in_tdata;   // raw_temp[19:0], raw_press[39:20]
  logic        out_tvalid;
  logic        out_tready;
  logic [79:0] out_tdata;  // temp_centi[15:0], fine_temp[47:16], pressure_q24_8[79:48]
  logic        out_tuser;  // divide_fault
  logic        cfg_we;
  logic [1:0]  cfg_addr;
  logic [47:0] cfg_wdata;

  bit [47:0] cal [4];
  bit [39:0] raw_q [$];
  comp_t     comp_q [$];
  int        errors;
  int        idle_cycles;
  int        rx_hold;
  int        gap_left;
  int        burst_left;
  int        rx_mode;
  int        rx_count;
  bit        item_taken;

  pressure_temperature_compensation uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  function automatic bit [63:0] sar(bit [63:0] x, int n);
    return $signed(x) >>> n;
  endfunction

  function automatic bit [63:0] sx16(bit [47:0] r, int pos);
    return {{48{r[pos+15]}}, r[pos +: 16]};
  endfunction

  function automatic comp_t compensate(bit [19:0] rt, bit [19:0] rp);
    bit [63:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
    bit [63:0] at, ap, a, b, tf, tc, v1, v2, p, s, un, ud, q;
    comp_t r;
    t1 = {48'd0, cal[0][15:0]};
    t2 = sx16(cal[0], 16);
    t3 = sx16(cal[0], 32);
    p1 = {48'd0, cal[1][15:0]};
    p2 = sx16(cal[1], 16);
    p3 = sx16(cal[1], 32);
    p4 = sx16(cal[2], 0);
    p5 = sx16(cal[2], 16);
    p6 = sx16(cal[2], 32);
    p7 = sx16(cal[3], 0);
    p8 = sx16(cal[3], 16);
    p9 = sx16(cal[3], 32);
    at = {44'd0, rt};
    ap = {44'd0, rp};
    a = sar(((at >> 3) - (t1 << 1)) * t2, 11);
    b = (at >> 4) - t1;
    b = sar(sar(b * b, 12) * t3, 14);
    tf = a + b;
    tc = sar(tf * 64'd5 + 64'd128, 8);
    if (tc[63]) begin
      if (tc < 64'hFFFF_FFFF_FFFF_8000) tc = 64'hFFFF_FFFF_FFFF_8000;
    end else if (tc > 64'd32767) begin
      tc = 64'd32767;
    end
    r.tc = tc[15:0];
    r.tf = tf[31:0];
    v1 = tf - 64'd128000;
    v2 = v1 * v1 * p6;
    v2 = v2 + ((v1 * p5) << 17);
    v2 = v2 + (p4 << 35);
    v1 = sar(v1 * v1 * p3, 8) + ((v1 * p2) << 12);
    v1 = sar((V1_BIAS + v1) * p1, 33);
    if (v1 == 64'd0) begin
      r.press = '0;
      r.fault = 1'b1;
      return r;
    end
    p = 64'd1048576 - ap;
    p = ((p << 31) - v2) * 64'd3125;
    un = p[63] ? -p : p;
    ud = v1[63] ? -v1 : v1;
    q = un / ud;
    p = (p[63] != v1[63]) ? -q : q;
    s = sar(p, 13);
    a = sar(p9 * s * s, 25);
    b = sar(p8 * p, 19);
    p = sar(p + a + b, 8) + (p7 << 4);
    if (p[63]) p = 64'd0;
    else if (p > 64'hFFFF_FFFF) p = 64'hFFFF_FFFF;
    r.press = p[31:0];
    r.fault = 1'b0;
    return r;
  endfunction

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // sender: bursts and gaps
  always @(negedge clk) begin
    logic       v_nx;
    logic [39:0] d_nx;
    v_nx = in_tvalid;
    d_nx = in_tdata;
    if (!rst_n) begin
      v_nx = 1'b0;
    end else if (!in_tvalid || item_taken) begin
      v_nx = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
      end else if (raw_q.size() > 0) begin
        d_nx = raw_q.pop_front();
        v_nx = 1'b1;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 40);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
      end
    end
    in_tvalid <= v_nx;
    in_tdata  <= d_nx;
  end

  // receiver stall pattern
  always @(negedge clk) begin
    logic r_nx;
    rx_count++;
    if (rx_count % 97 == 0) rx_mode = $urandom_range(0, 3);
    if (rx_hold > 0) begin
      rx_hold--;
      r_nx = 1'b0;
    end else begin
      case (rx_mode)
        0: r_nx = 1'b1;
        1: r_nx = ($urandom_range(0, 3) != 0);
        2: r_nx = ($urandom_range(0, 3) == 0);
        default: r_nx = ((rx_count % 8) < 5);
      endcase
    end
    out_tready <= r_nx;
  end

  // input capture, result check, watchdog
  always @(posedge clk) begin
    comp_t e;
    item_taken <= in_tvalid && in_tready && rst_n;
    if (rst_n) begin
      if (in_tvalid && in_tready) comp_q.push_back(compensate(in_tdata[19:0], in_tdata[39:20]));
      if (out_tvalid && out_tready) begin
        if (comp_q.size() == 0) begin
          $error("result with nothing expected: tdata %h", out_tdata);
          errors++;
        end else begin
          e = comp_q.pop_front();
          if (out_tdata[15:0] !== e.tc) begin
            $error("temp_centi expected %h actual %h", e.tc, out_tdata[15:0]);
            errors++;
          end
          if (out_tdata[47:16] !== e.tf) begin
            $error("fine_temp expected %h actual %h", e.tf, out_tdata[47:16]);
            errors++;
          end
          if (out_tdata[79:48] !== e.press) begin
            $error("pressure_q24_8 expected %h actual %h", e.press, out_tdata[79:48]);
            errors++;
          end
          if (out_tuser !== e.fault) begin
            $error("divide_fault expected %b actual %b", e.fault, out_tuser);
            errors++;
          end
        end
      end
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= 5000) begin
        $display("FAIL pressure_temperature_compensation");
        $finish;
      end
    end
  end

  task automatic write_cal(logic [1:0] idx, bit [47:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    cal[idx]  = val;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic load_cal(bit [47:0] c0, bit [47:0] c1, bit [47:0] c2, bit [47:0] c3);
    write_cal(CFG_CAL_TEMP, c0);
    write_cal(CFG_CAL_PRESS_A, c1);
    write_cal(CFG_CAL_PRESS_B, c2);
    write_cal(CFG_CAL_PRESS_C, c3);
  endtask

  task automatic drain;
    wait (raw_q.size() == 0 && comp_q.size() == 0 && !in_tvalid);
    repeat (100) @(negedge clk);
  endtask

  function automatic bit [47:0] rnd48();
    return {16'($urandom), $urandom};
  endfunction

  function automatic bit [39:0] rnd_raw();
    return {20'($urandom_range(0, 20'hFFFFF)), 20'($urandom_range(0, 20'hFFFFF))};
  endfunction

  task automatic add_random(int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 3) == 0) raw_q.push_back(rnd_raw());
      else raw_q.push_back({20'($urandom_range(300000, 700000)),
                            20'($urandom_range(400000, 600000))});
    end
  endtask

  task automatic jitter_typical;
    load_cal({16'hFC18 ^ 16'($urandom_range(0, 255)), 16'd26435 ^ 16'($urandom_range(0, 255)),
              16'd27504 ^ 16'($urandom_range(0, 255))},
             {16'd3024 ^ 16'($urandom_range(0, 255)), 16'hD643 ^ 16'($urandom_range(0, 255)),
              16'd36477 ^ 16'($urandom_range(0, 255))},
             {16'hFFF9 ^ 16'($urandom_range(0, 15)), 16'd140 ^ 16'($urandom_range(0, 63)),
              16'd2855 ^ 16'($urandom_range(0, 255))},
             {16'd6000 ^ 16'($urandom_range(0, 255)), 16'hC6F8 ^ 16'($urandom_range(0, 255)),
              16'd15500 ^ 16'($urandom_range(0, 255))});
  endtask

  initial begin
    errors = 0;
    idle_cycles = 0;
    rx_hold = 0;
    gap_left = 0;
    burst_left = 0;
    rx_mode = 0;
    rx_count = 0;
    item_taken = 1'b0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    out_tready = 1'b0;
    cfg_we = 1'b0;
    cfg_addr = CFG_CAL_TEMP;
    cfg_wdata = '0;
    foreach (cal[i]) cal[i] = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // reset calibration: zero divisor on every item
    raw_q.push_back(40'h0);
    raw_q.push_back({20'hFFFFF, 20'hFFFFF});
    add_random(30);
    drain();

    // typical coefficients, field extremes
    load_cal({16'hFC18, 16'd26435, 16'd27504}, {16'd3024, 16'hD643, 16'd36477},
             {16'hFFF9, 16'd140, 16'd2855}, {16'd6000, 16'hC6F8, 16'd15500});
    raw_q.push_back({20'h00000, 20'h00000});
    raw_q.push_back({20'hFFFFF, 20'hFFFFF});
    raw_q.push_back({20'hFFFFF, 20'h00000});
    raw_q.push_back({20'h00000, 20'hFFFFF});
    raw_q.push_back({20'h80000, 20'h7FFFF});
    raw_q.push_back({20'h7FFFF, 20'h80000});
    raw_q.push_back({20'd415148, 20'd519888});
    raw_q.push_back({20'h55555, 20'hAAAAA});
    raw_q.push_back({20'hAAAAA, 20'h55555});
    add_random(100);
    drain();

    // all-ones and sign extremes
    load_cal(48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF);
    raw_q.push_back(40'h0);
    raw_q.push_back({20'hFFFFF, 20'hFFFFF});
    add_random(60);
    drain();
    load_cal({16'h8000, 16'h7FFF, 16'h0000}, {16'h8000, 16'h7FFF, 16'hFFFF},
             {16'h7FFF, 16'h8000, 16'h7FFF}, {16'h8000, 16'h7FFF, 16'h8000});
    raw_q.push_back(40'h0);
    raw_q.push_back({20'hFFFFF, 20'hFFFFF});
    add_random(60);
    drain();
    load_cal({16'h7FFF, 16'h8000, 16'hFFFF}, {16'h7FFF, 16'h8000, 16'h0001},
             {16'h8000, 16'h7FFF, 16'h8000}, {16'h7FFF, 16'h8000, 16'h7FFF});
    add_random(60);
    drain();

    // long output stall while items keep coming
    jitter_typical();
    rx_hold = 400;
    add_random(150);
    drain();

    // random and jittered typical coefficient sets
    for (int ph = 0; ph < 8; ph++) begin
      if (ph % 2 == 0) load_cal(rnd48(), rnd48(), rnd48(), rnd48());
      else jitter_typical();
      add_random(55);
      drain();
    end

    if (errors == 0) begin
      $display("PASS pressure_temperature_compensation");
    end else begin
      $display("FAIL pressure_temperature_compensation");
    end
    $finish;
  end

endmodule
